>>> rtl/core/lcdfb_pkg.sv
// Package for the page framebuffer: types, constants and helper functions.
`default_nettype none
package lcdfb_pkg;

    localparam int COLUMNS     = 192;
    localparam int PAGES       = 8;
    localparam int CHUNK_BYTES = 8;
    localparam int DEPTH       = PAGES * COLUMNS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CHUNK_IW    = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    // Opcodes
    localparam logic [2:0] OP_PIXEL   = 3'd0;
    localparam logic [2:0] OP_FILL    = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_DISPLAY = 3'd3;
    localparam logic [2:0] OP_SCAN    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOPENDING = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_PORTRAIT = 2'd2;

    // Controller command bytes
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HI   = 8'h10;
    localparam logic [7:0] CMD_COL_LO   = 8'h00;
    localparam logic [7:0] PAGE_MASK    = 8'h07;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] CMD_DISP_ON  = 8'hAF;
    localparam logic [7:0] CMD_DISP_OFF = 8'hAE;
    localparam logic [7:0] CMD_SCAN_0   = 8'hC4;
    localparam logic [7:0] CMD_SCAN_180 = 8'hC2;

    localparam logic [7:0] W_RESET = 8'd192;
    localparam logic [6:0] H_RESET = 7'd64;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] x_start;
        logic [7:0] x_end;
        logic [7:0] y_start;
        logic [7:0] y_end;
        logic       color;
        logic       setting_value;
    } t_cmd;

    typedef struct packed {
        logic        is_data;
        logic [63:0] payload;
        logic [3:0]  byte_count;
        logic [1:0]  status;
        logic        more_pages;
        logic        last;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_PIX_RD,
        S_PIX_WR,
        S_ADDR_PG,
        S_ADDR_LO,
        S_ADDR_HI,
        S_PIX_DATA,
        S_FILL_RD,
        S_FILL_WR,
        S_FILL_DONE,
        S_REF_RD,
        S_REF_CAP
    } t_state;

    function automatic t_result mk_result(input logic is_data, input logic [63:0] payload,
                                          input logic [3:0] count, input logic [1:0] status,
                                          input logic more, input logic last);
        t_result r;
        r.is_data    = is_data;
        r.payload    = payload;
        r.byte_count = count;
        r.status     = status;
        r.more_pages = more;
        r.last       = last;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                      input logic [7:0] col);
        logic [ADDR_W+8:0] a;
        a = ADDR_W'(page) * (ADDR_W+9)'(COLUMNS) + (ADDR_W+9)'(col);
        return a[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/mono_lcd_page_framebuffer_top.sv
// Top level: sequencer around the frame store for a page-addressed mono LCD.
// After reset the block clears its 1536-byte frame store, one byte a cycle, holding busy
// high meanwhile. A transaction is taken when start is high and busy is low; results
// come at most one per cycle, each marked by o_strobe for one cycle, and cannot be held off.
// A pixel is read, written back and sent as page, low and high column commands and its data
// byte; a fill reads and writes back each painted pixel and skips the others; a refresh sends
// the page and column commands, then reads the column bytes one by one from the single port.
// The last result of a transaction comes in the same cycle that busy drops.
`default_nettype none
module mono_lcd_page_framebuffer_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire lcdfb_pkg::t_cmd   i_cmd,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    output logic                   o_strobe,
    output lcdfb_pkg::t_result     o_result
);
    import lcdfb_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_in;
    logic [7:0] r_w;
    logic [6:0] r_h;
    logic       r_portrait;
    logic [7:0] r_col_first, n_col_first, r_col_last, n_col_last;
    logic [PAGE_W-1:0] r_page_next, n_page_next, r_page_last, n_page_last;
    logic       r_pending, n_pending, r_disp_on, n_disp_on, r_scan, n_scan;
    logic [7:0] r_a, n_a, r_b, n_b, r_col, n_col, r_c, n_c;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_byte, n_byte;
    logic [63:0] r_chunk, n_chunk;
    logic [CHUNK_IW-1:0] r_n, n_n;
    logic       r_more, n_more;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic       n_strobe;
    t_result    n_result;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic [7:0] w_eff, h_eff;
    logic [7:0] sx, ex, sy, ey;
    logic [7:0] px_col, px_row, f_col, f_row;
    logic       px_ok, f_ok;
    logic [7:0] sc, ec;
    logic [7:0] sp, ep;
    logic       win_ok;
    logic       a_end, b_end, last_byte, chunk_full;
    logic [7:0] fill_byte, pix_byte;

    lcdfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Effective sizes and clamped rectangle
    always_comb begin
        w_eff = (r_w == 8'd0) ? 8'd1 : r_w;
        h_eff = (r_h == 7'd0) ? 8'd1 : {1'b0, r_h};
        sx = (r_in.x_start >= w_eff) ? w_eff - 8'd1 : r_in.x_start;
        ex = (r_in.x_end   >= w_eff) ? w_eff - 8'd1 : r_in.x_end;
        sy = (r_in.y_start >= h_eff) ? h_eff - 8'd1 : r_in.y_start;
        ey = (r_in.y_end   >= h_eff) ? h_eff - 8'd1 : r_in.y_end;
    end

    // Map the single pixel and the current fill pixel onto column and row
    always_comb begin
        px_col = r_portrait ? r_in.y_start : r_in.x_start;
        px_row = r_portrait ? w_eff - 8'd1 - r_in.x_start : r_in.y_start;
        px_ok  = (r_in.x_start < w_eff) && (r_in.y_start < h_eff)
                 && (9'(px_col) < 9'(COLUMNS)) && (9'(px_row[7:3]) < 9'(PAGES));
        f_col  = r_portrait ? r_b : r_a;
        f_row  = r_portrait ? w_eff - 8'd1 - r_a : r_b;
        f_ok   = (9'(f_col) < 9'(COLUMNS)) && (9'(f_row[7:3]) < 9'(PAGES));
    end

    // Refresh window of the rectangle, merged with any pending one
    always_comb begin
        if (r_portrait) begin
            sc = sy;
            ec = ey;
            sp = {3'd0, 5'((w_eff - 8'd1 - ex) >> 3)};
            ep = {3'd0, 5'((w_eff - 8'd1 - sx) >> 3)};
        end else begin
            sc = sx;
            ec = ex;
            sp = {3'd0, sy[7:3]};
            ep = {3'd0, ey[7:3]};
        end
        if (9'(ec) > 9'(COLUMNS - 1)) ec = 8'(COLUMNS - 1);
        if (ep > 8'(PAGES - 1))      ep = 8'(PAGES - 1);
        win_ok = (sc <= ec) && (sp <= ep);
        if (r_pending) begin
            if (r_col_first < sc)         sc = r_col_first;
            if (r_col_last > ec)          ec = r_col_last;
            if (8'(r_page_next) < sp)     sp = 8'(r_page_next);
            if (8'(r_page_last) > ep)     ep = 8'(r_page_last);
        end
    end

    always_comb begin
        a_end      = (r_a == ex);
        b_end      = (r_b == ey);
        last_byte  = (r_c == r_col_last);
        chunk_full = (32'(r_n) == CHUNK_BYTES - 1);
        fill_byte  = r_in.color ? (ram_rdata | (8'd1 << f_row[2:0]))
                                : (ram_rdata & ~(8'd1 << f_row[2:0]));
        pix_byte   = r_in.color ? (ram_rdata | (8'd1 << r_bit))
                                : (ram_rdata & ~(8'd1 << r_bit));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (32'(r_clr) == DEPTH - 1) n_state = S_IDLE;
            S_IDLE:     if (start) n_state = S_DECODE;
            S_DECODE: begin
                unique case (r_in.opcode)
                    OP_PIXEL:   n_state = px_ok ? S_PIX_RD : S_IDLE;
                    OP_FILL:    n_state = ((sx <= ex) && (sy <= ey)) ? S_FILL_RD : S_FILL_DONE;
                    OP_REFRESH: n_state = r_pending ? S_ADDR_PG : S_IDLE;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_PIX_RD:   n_state = S_PIX_WR;
            S_PIX_WR:   n_state = S_ADDR_PG;
            S_ADDR_PG:  n_state = S_ADDR_LO;
            S_ADDR_LO:  n_state = S_ADDR_HI;
            S_ADDR_HI:  n_state = (r_in.opcode == OP_PIXEL) ? S_PIX_DATA : S_REF_RD;
            S_PIX_DATA: n_state = S_IDLE;
            S_FILL_RD: begin
                if (f_ok)                  n_state = S_FILL_WR;
                else if (a_end && b_end)   n_state = S_FILL_DONE;
            end
            S_FILL_WR:  n_state = (a_end && b_end) ? S_FILL_DONE : S_FILL_RD;
            S_FILL_DONE: n_state = S_IDLE;
            S_REF_RD:   n_state = S_REF_CAP;
            S_REF_CAP:  n_state = last_byte ? S_IDLE : S_REF_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath, store port and results
    always_comb begin
        n_col_first = r_col_first;
        n_col_last  = r_col_last;
        n_page_next = r_page_next;
        n_page_last = r_page_last;
        n_pending   = r_pending;
        n_disp_on   = r_disp_on;
        n_scan      = r_scan;
        n_a         = r_a;
        n_b         = r_b;
        n_col       = r_col;
        n_c         = r_c;
        n_page      = r_page;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_chunk     = r_chunk;
        n_n         = r_n;
        n_more      = r_more;
        n_clr       = r_clr;
        n_strobe    = 1'b0;
        n_result    = mk_result(1'b0, 64'd0, 4'd0, ST_OK, r_pending, 1'b1);
        ram_we      = 1'b0;
        ram_addr    = store_addr(r_page, r_col);
        ram_wdata   = 8'd0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + ADDR_W'(1);
            end
            S_IDLE: ;
            S_DECODE: begin
                n_more = r_pending;
                unique case (r_in.opcode)
                    OP_PIXEL: begin
                        n_col  = px_col;
                        n_page = PAGE_W'(px_row[7:3]);
                        n_bit  = px_row[2:0];
                        if (!px_ok) begin
                            n_strobe = 1'b1;
                            n_result = mk_result(1'b0, 64'd0, 4'd0, ST_RANGE, r_pending, 1'b1);
                        end
                    end
                    OP_FILL: begin
                        n_a = sx;
                        n_b = sy;
                    end
                    OP_REFRESH: begin
                        if (!r_pending) begin
                            n_strobe = 1'b1;
                            n_result = mk_result(1'b0, 64'd0, 4'd0, ST_NOPENDING,
                                                 r_pending, 1'b1);
                        end
                        n_page  = r_page_next;
                        n_col   = r_col_first;
                        n_c     = r_col_first;
                        n_more  = (r_page_next < r_page_last);
                        n_n     = '0;
                        n_chunk = 64'd0;
                    end
                    OP_DISPLAY: begin
                        if (r_disp_on != r_in.setting_value) begin
                            n_disp_on = r_in.setting_value;
                            n_strobe  = 1'b1;
                            n_result  = mk_result(1'b0, {56'd0, r_in.setting_value ?
                                                  CMD_DISP_ON : CMD_DISP_OFF},
                                                  4'd1, ST_OK, r_pending, 1'b1);
                        end
                    end
                    OP_SCAN: begin
                        if (r_scan != r_in.setting_value) begin
                            n_scan   = r_in.setting_value;
                            n_strobe = 1'b1;
                            n_result = mk_result(1'b0, {56'd0, r_in.setting_value ?
                                                 CMD_SCAN_180 : CMD_SCAN_0},
                                                 4'd1, ST_OK, r_pending, 1'b1);
                        end
                    end
                    default: ;
                endcase
            end
            S_PIX_RD: ;
            S_PIX_WR: begin
                ram_we    = 1'b1;
                ram_wdata = pix_byte;
                n_byte    = pix_byte;
            end
            S_ADDR_PG: begin
                n_strobe = 1'b1;
                n_result = mk_result(1'b0, {56'd0, CMD_PAGE | (8'(r_page) & PAGE_MASK)},
                                     4'd1, ST_OK, r_more, 1'b0);
            end
            S_ADDR_LO: begin
                n_strobe = 1'b1;
                n_result = mk_result(1'b0, {56'd0, CMD_COL_LO | (r_col & NIBBLE_MASK)},
                                     4'd1, ST_OK, r_more, 1'b0);
            end
            S_ADDR_HI: begin
                n_strobe = 1'b1;
                n_result = mk_result(1'b0, {56'd0, CMD_COL_HI | ((r_col >> 4) & NIBBLE_MASK)},
                                     4'd1, ST_OK, r_more, 1'b0);
            end
            S_PIX_DATA: begin
                n_strobe = 1'b1;
                n_result = mk_result(1'b1, {56'd0, r_byte}, 4'd1, ST_OK, r_more, 1'b1);
            end
            S_FILL_RD, S_FILL_WR: begin
                ram_addr = store_addr(PAGE_W'(f_row[7:3]), f_col);
                if (r_state == S_FILL_WR) begin
                    ram_we    = 1'b1;
                    ram_wdata = fill_byte;
                end
                // Advance through the rectangle when this pixel is done
                if (r_state == S_FILL_WR || !f_ok) begin
                    if (a_end) begin
                        n_a = sx;
                        if (!b_end) n_b = r_b + 8'd1;
                    end else begin
                        n_a = r_a + 8'd1;
                    end
                end
            end
            S_FILL_DONE: begin
                if (win_ok) begin
                    n_col_first = sc;
                    n_col_last  = ec;
                    n_page_next = PAGE_W'(sp);
                    n_page_last = PAGE_W'(ep);
                    n_pending   = 1'b1;
                end
                n_strobe = 1'b1;
                n_result = mk_result(1'b0, 64'd0, 4'd0, ST_OK, r_pending | win_ok, 1'b1);
            end
            S_REF_RD: begin
                ram_addr = store_addr(r_page, r_c);
            end
            S_REF_CAP: begin
                ram_addr = store_addr(r_page, r_c);
                n_chunk = r_chunk;
                n_chunk[8*r_n +: 8] = ram_rdata;
                n_c = r_c + 8'd1;
                n_n = r_n + CHUNK_IW'(1);
                if (last_byte || chunk_full) begin
                    n_strobe = 1'b1;
                    n_result = mk_result(1'b1, n_chunk, 4'(r_n) + 4'd1, ST_OK, r_more,
                                         last_byte);
                    n_n     = '0;
                    n_chunk = 64'd0;
                end
                // Step the refresh window on the final chunk
                if (last_byte) begin
                    if (r_page_next >= r_page_last) n_pending = 1'b0;
                    else n_page_next = r_page_next + PAGE_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_w         <= W_RESET;
            r_h         <= H_RESET;
            r_portrait  <= 1'b0;
            r_col_first <= 8'd0;
            r_col_last  <= 8'd0;
            r_page_next <= '0;
            r_page_last <= '0;
            r_pending   <= 1'b0;
            r_disp_on   <= 1'b0;
            r_scan      <= 1'b0;
            o_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_col_first <= n_col_first;
            r_col_last  <= n_col_last;
            r_page_next <= n_page_next;
            r_page_last <= n_page_last;
            r_pending   <= n_pending;
            r_disp_on   <= n_disp_on;
            r_scan      <= n_scan;
            o_strobe    <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:    r_w        <= i_cfg_data;
                    CFG_HEIGHT:   r_h        <= i_cfg_data[6:0];
                    CFG_PORTRAIT: r_portrait <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) r_in <= i_cmd;
        r_a      <= n_a;
        r_b      <= n_b;
        r_col    <= n_col;
        r_c      <= n_c;
        r_page   <= n_page;
        r_bit    <= n_bit;
        r_byte   <= n_byte;
        r_chunk  <= n_chunk;
        r_n      <= n_n;
        r_more   <= n_more;
        o_result <= n_result;
    end

    assign busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

>>> rtl/core/lcdfb_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module lcdfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> tb/mono_lcd_page_framebuffer_top_tb.sv
// Testbench for the page framebuffer: random and directed drawing transactions checked by a predictor.
`timescale 1ns / 1ps
module mono_lcd_page_framebuffer_top_tb;
    import lcdfb_pkg::*;

    // Frame store predictor and queue of expected controller transfers
    class lcd_scoreboard;
        logic [7:0] shadow [0:DEPTH-1];
        int unsigned col_first, col_last, page_next, page_last;
        bit          win_pending, disp_on, scan_flip;
        logic [7:0]  panel_w;
        logic [6:0]  panel_h;
        bit          portrait;
        t_result     due [$];
        t_result     batch [$];
        int          errors;

        function new();
            foreach (shadow[i]) shadow[i] = 8'h00;
            col_first = 0; col_last = 0; page_next = 0; page_last = 0;
            win_pending = 0; disp_on = 0; scan_flip = 0;
            panel_w = W_RESET; panel_h = H_RESET; portrait = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_WIDTH:    panel_w = val;
                CFG_HEIGHT:   panel_h = val[6:0];
                CFG_PORTRAIT: portrait = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_w();
            return (panel_w == 0) ? 1 : panel_w;
        endfunction

        function int unsigned eff_h();
            return (panel_h == 0) ? 1 : panel_h;
        endfunction

        function bit map_xy(int unsigned x, int unsigned y,
                            output int unsigned col, output int unsigned row);
            if (portrait) begin
                col = y;
                row = eff_w() - 1 - x;
            end else begin
                col = x;
                row = y;
            end
            return col < COLUMNS && (row >> 3) < PAGES;
        endfunction

        function void paint(int unsigned col, int unsigned row, bit colour);
            int unsigned idx;
            idx = (row >> 3) * COLUMNS + col;
            if (colour) shadow[idx] = shadow[idx] | (8'h01 << (row & 7));
            else        shadow[idx] = shadow[idx] & ~(8'h01 << (row & 7));
        endfunction

        function void add(bit is_data, logic [63:0] pay, logic [3:0] cnt, logic [1:0] st);
            t_result r;
            r = '0;
            r.is_data = is_data;
            r.payload = pay;
            r.byte_count = cnt;
            r.status = st;
            batch.push_back(r);
        endfunction

        function void add_addr(int unsigned page, int unsigned col);
            add(0, 64'(CMD_PAGE | (8'(page) & PAGE_MASK)), 1, ST_OK);
            add(0, 64'(CMD_COL_LO | (8'(col) & NIBBLE_MASK)), 1, ST_OK);
            add(0, 64'(CMD_COL_HI | (8'(col >> 4) & NIBBLE_MASK)), 1, ST_OK);
        endfunction

        function int unsigned clampv(int unsigned v, int unsigned lim);
            return (v >= lim) ? lim - 1 : v;
        endfunction

        // Work out the transfers caused by one accepted transaction
        function void note_cmd(t_cmd c);
            int unsigned w, h, col, row, sx, ex, sy, ey, sc, ec, sp, ep, p, cc, n;
            logic [63:0] pay;
            w = eff_w();
            h = eff_h();
            batch.delete();
            case (c.opcode)
                OP_PIXEL: begin
                    if (c.x_start >= w || c.y_start >= h || !map_xy(c.x_start, c.y_start, col, row))
                        add(0, 0, 0, ST_RANGE);
                    else begin
                        paint(col, row, c.color);
                        add_addr(row >> 3, col);
                        add(1, 64'(shadow[(row >> 3) * COLUMNS + col]), 1, ST_OK);
                    end
                end
                OP_FILL: begin
                    sx = clampv(c.x_start, w); ex = clampv(c.x_end, w);
                    sy = clampv(c.y_start, h); ey = clampv(c.y_end, h);
                    for (int unsigned b = sy; b <= ey; b++)
                        for (int unsigned a = sx; a <= ex; a++)
                            if (map_xy(a, b, col, row)) paint(col, row, c.color);
                    if (portrait) begin
                        sc = sy; ec = ey;
                        sp = (w - 1 - ex) >> 3;
                        ep = (w - 1 - sx) >> 3;
                    end else begin
                        sc = sx; ec = ex;
                        sp = sy >> 3;
                        ep = ey >> 3;
                    end
                    if (ec > COLUMNS - 1) ec = COLUMNS - 1;
                    if (ep > PAGES - 1) ep = PAGES - 1;
                    if (sc <= ec && sp <= ep) begin
                        // merge into the pending window as a bounding box
                        if (win_pending) begin
                            if (col_first < sc) sc = col_first;
                            if (col_last > ec) ec = col_last;
                            if (page_next < sp) sp = page_next;
                            if (page_last > ep) ep = page_last;
                        end
                        col_first = sc; col_last = ec;
                        page_next = sp; page_last = ep;
                        win_pending = 1;
                    end
                    add(0, 0, 0, ST_OK);
                end
                OP_REFRESH: begin
                    if (!win_pending) add(0, 0, 0, ST_NOPENDING);
                    else begin
                        p = page_next & 7;
                        cc = col_first;
                        add_addr(p, cc);
                        while (cc <= col_last && cc < COLUMNS && p < PAGES) begin
                            pay = 0;
                            n = 0;
                            while (n < CHUNK_BYTES && cc <= col_last && cc < COLUMNS) begin
                                pay |= 64'(shadow[p * COLUMNS + cc]) << (8 * n);
                                n++;
                                cc++;
                            end
                            add(1, pay, 4'(n), ST_OK);
                        end
                        if (p >= page_last) win_pending = 0;
                        else page_next = p + 1;
                    end
                end
                OP_DISPLAY: begin
                    if (disp_on != c.setting_value) begin
                        disp_on = c.setting_value;
                        add(0, 64'(c.setting_value ? CMD_DISP_ON : CMD_DISP_OFF), 1, ST_OK);
                    end
                end
                OP_SCAN: begin
                    if (scan_flip != c.setting_value) begin
                        scan_flip = c.setting_value;
                        add(0, 64'(c.setting_value ? CMD_SCAN_180 : CMD_SCAN_0), 1, ST_OK);
                    end
                end
                default: ;
            endcase
            foreach (batch[i]) begin
                batch[i].more_pages = win_pending;
                batch[i].last = (i == batch.size() - 1);
                due.push_back(batch[i]);
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 40)
                $display("mismatch %0d at %0t: %s got %h want %h", errors, $time, what, got, want);
        endtask

        // Compare one strobed transfer against the oldest expectation
        task check_result(t_result r);
            t_result e;
            if (due.size() == 0) begin
                report("unexpected transfer", r.payload, 0);
                return;
            end
            e = due.pop_front();
            if (r.is_data !== e.is_data) report("is_data", r.is_data, e.is_data);
            if (r.payload !== e.payload) report("payload", r.payload, e.payload);
            if (r.byte_count !== e.byte_count) report("byte_count", r.byte_count, e.byte_count);
            if (r.status !== e.status) report("status", r.status, e.status);
            if (r.more_pages !== e.more_pages) report("more_pages", r.more_pages, e.more_pages);
            if (r.last !== e.last) report("last", r.last, e.last);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_cmd        i_cmd = '0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = CFG_WIDTH;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        o_strobe;
    t_result     o_result;
    int unsigned cycles = 0;
    lcd_scoreboard sb = new();

    mono_lcd_page_framebuffer_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Check every strobed transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 60000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold start with the command until the block takes the transaction
    task send(t_cmd c);
        start <= 1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note_cmd(c);
    endtask

    task send_op(logic [2:0] op, logic [7:0] xs, logic [7:0] xe, logic [7:0] ys,
                 logic [7:0] ye, logic colour, logic sv);
        t_cmd c;
        c.opcode = op; c.x_start = xs; c.x_end = xe; c.y_start = ys; c.y_end = ye;
        c.color = colour; c.setting_value = sv;
        send(c);
    endtask

    // Drop start and wait out all expected transfers plus settling time
    task drain();
        start <= 0;
        do @(posedge i_clk); while (sb.due.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 0;
    endtask

    task random_cmd();
        t_cmd c;
        int unsigned w, h, sel;
        w = sb.eff_w();
        h = sb.eff_h();
        c = '0;
        c.color = 1'($urandom_range(0, 1));
        c.setting_value = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            c.opcode = OP_PIXEL;
            c.x_start = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, w - 1));
            c.y_start = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, h - 1));
            c.x_end = 8'($urandom_range(0, 255));
            c.y_end = 8'($urandom_range(0, 255));
        end else if (sel < 65) begin
            c.opcode = OP_FILL;
            c.x_start = 8'($urandom_range(0, 255));
            c.y_start = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) c.x_start = 8'($urandom_range(0, w - 1));
            if ($urandom_range(0, 3) == 0) c.y_start = 8'($urandom_range(0, h - 1));
            if ($urandom_range(0, 39) == 0) begin
                c.x_end = 8'($urandom_range(0, 255));
                c.y_end = 8'($urandom_range(0, 255));
            end else begin
                // mostly small rectangles, some reversed
                c.x_end = 8'(c.x_start + $urandom_range(0, 9) - 2);
                c.y_end = 8'(c.y_start + $urandom_range(0, 12) - 2);
            end
        end else if (sel < 88) begin
            c.opcode = OP_REFRESH;
            c.x_start = 8'($urandom_range(0, 255));
        end else if (sel < 96) begin
            c.opcode = $urandom_range(0, 1) ? OP_DISPLAY : OP_SCAN;
        end else begin
            c.opcode = 3'($urandom_range(5, 7));
            c.x_start = 8'($urandom_range(0, 255));
        end
        send(c);
    endtask

    initial begin
        logic [7:0] ws [7] = '{8'd192, 8'd192, 8'd1, 8'd0, 8'd100, 8'd255, 8'd255};
        logic [7:0] hs [7] = '{8'd64, 8'd64, 8'd1, 8'd0, 8'd40, 8'd127, 8'd127};
        logic [7:0] ps [7] = '{8'd0, 8'd1, 8'd0, 8'd1, 8'd1, 8'd0, 8'd1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: corners, out-of-range pixels, full fill and its refresh
        send_op(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0);
        send_op(OP_PIXEL, 8'd191, 8'd255, 8'd63, 8'd255, 1, 1);
        send_op(OP_PIXEL, 8'd191, 8'd0, 8'd63, 8'd0, 0, 0);
        send_op(OP_PIXEL, 8'd192, 8'd0, 8'd0, 8'd0, 1, 0);
        send_op(OP_PIXEL, 8'd0, 8'd0, 8'd64, 8'd0, 1, 0);
        send_op(OP_PIXEL, 8'd255, 8'd0, 8'd255, 8'd0, 1, 0);
        send_op(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        send_op(OP_FILL, 8'd0, 8'd255, 8'd0, 8'd255, 1, 0);
        send_op(OP_FILL, 8'd100, 8'd10, 8'd5, 8'd5, 1, 0);
        send_op(OP_FILL, 8'd3, 8'd13, 8'd9, 8'd30, 0, 1);
        for (int i = 0; i < 9; i++) send_op(OP_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        send_op(OP_DISPLAY, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        send_op(OP_DISPLAY, 8'd0, 8'd0, 8'd0, 8'd0, 0, 1);
        send_op(OP_DISPLAY, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        send_op(OP_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 0, 1);
        send_op(OP_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        send_op(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1);
        send_op(3'd5, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);

        // Random phases, one register setting each; no idling in the last phase
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_reg(CFG_WIDTH, ws[ph]);
            write_reg(CFG_HEIGHT, hs[ph]);
            write_reg(CFG_PORTRAIT, ps[ph]);
            for (int i = 0; i < 30; i++) begin
                if (ph < 6 && $urandom_range(0, 3) == 0) begin
                    start <= 0;
                    repeat ($urandom_range(1, 16)) @(posedge i_clk);
                end
                random_cmd();
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/core/lcdfb_pkg.sv
rtl/core/lcdfb_ram.sv
rtl/core/mono_lcd_page_framebuffer_top.sv
tb/mono_lcd_page_framebuffer_top_tb.sv
